FILE: hw/rtl/gnlms_pkg.sv
// gnlms_pkg: shared types and constants for the gated nlms ramp identifier
// holds config register codes, sequencer states and the control/status structs
// no dependencies

package gnlms_pkg;

    // fixed-point result width (q16.16)
    localparam int Q_W = 32;
    localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;

    // configuration register widths and reset values
    localparam int ON_START_W   = 10;
    localparam int END_MARGIN_W = 10;
    localparam int EPOCH_LEN_W  = 11;
    localparam int CFG_DATA_W   = 11;
    localparam int CFG_IDX_W    = 2;

    localparam logic [ON_START_W-1:0]   ON_START_RST   = 10'd5;
    localparam logic [END_MARGIN_W-1:0] END_MARGIN_RST = 10'd5;
    localparam logic [EPOCH_LEN_W-1:0]  EPOCH_LEN_RST  = 11'd100;

    // fractional bits added when widening a q8.8 sample to q16.16
    localparam int SMP_SHIFT = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ON_START     = 2'd0,
        CFG_END_MARGIN   = 2'd1,
        CFG_EPOCH_LENGTH = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRED,
        S_ERR,
        S_DEN,
        S_NUM,
        S_DIV,
        S_UPD,
        S_OUT
    } state_t;

    // operand selection of the shared multiplier
    typedef enum logic [1:0] {
        MUL_PRED,
        MUL_SQR,
        MUL_NUM
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     err_en;
        logic     den_en;
        logic     div_init;
        logic     div_step;
        logic     upd_en;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic gated;
    } status_t;

endpackage

FILE: hw/rtl/gnlms_ctrl.sv
// gnlms_ctrl: sequencer for the gated nlms ramp identifier
// walks one gated transaction through multiply, divide and update steps
// depends on gnlms_pkg

module gnlms_ctrl import gnlms_pkg::*; #(
    parameter int DIV_ITERS = 21
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam int CNT_W = $clog2(DIV_ITERS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_ITERS - 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.gated ? S_PRED : S_OUT;
                end
            end
            S_PRED: state_next = S_ERR;
            S_ERR:  state_next = S_DEN;
            S_DEN:  state_next = S_NUM;
            S_NUM:  state_next = S_DIV;
            S_DIV:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:  state_next = S_OUT;
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        cmd.mul_sel = MUL_PRED;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_PRED:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_PRED;
            end
            S_ERR:
            begin
                cmd.err_en  = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SQR;
            end
            S_DEN:
            begin
                cmd.den_en  = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_NUM;
            end
            S_NUM:   cmd.div_init = 1'b1;
            S_DIV:   cmd.div_step = 1'b1;
            S_UPD:   cmd.upd_en   = 1'b1;
            S_OUT:   cmd.out_load = !out_valid_reg || out_ready;
            default: cmd.load     = 1'b0;
        endcase
    end

    // divide step counter
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.div_init)
        begin
            cnt_next = '0;
        end
        else if (cmd.div_step)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    // output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: hw/rtl/gnlms_dp.sv
// gnlms_dp: datapath for the gated nlms ramp identifier
// config registers, gate logic, shared multiplier, two-lane radix-4 divider, weights
// depends on gnlms_pkg

module gnlms_dp import gnlms_pkg::*; #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int POS_WIDTH    = 10
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic [SAMPLE_WIDTH-1:0] sample,
    input  logic [POS_WIDTH-1:0]    edge_pos,
    input  cmd_t                    cmd,
    output status_t                 status,
    output logic [Q_W-1:0]          weight_offset,
    output logic [Q_W-1:0]          weight_slope,
    output logic [Q_W-1:0]          pred_error,
    output logic                    adapted,
    output logic                    epoch_done
);

    localparam int U1_W      = POS_WIDTH + 1;
    localparam int MUL_W     = Q_W + U1_W;
    localparam int SMP_W     = SAMPLE_WIDTH + SMP_SHIFT;
    localparam int DIFF_W    = ((MUL_W + 1 > SMP_W) ? MUL_W + 1 : SMP_W) + 1;
    localparam int DEN_W     = 2 * POS_WIDTH + 1;
    localparam int REM_W     = DEN_W + 1;
    localparam int NUM_W     = Q_W - 1 + POS_WIDTH;
    localparam int DIV_ITERS = (NUM_W + 1) / 2;
    localparam int DVD_W     = 2 * DIV_ITERS;
    localparam int SUM_W     = NUM_W + 2;
    localparam int CMP_W     = ((POS_WIDTH > EPOCH_LEN_W) ? POS_WIDTH : EPOCH_LEN_W) + 2;

    // configuration
    logic [ON_START_W-1:0]   on_start_reg;
    logic [END_MARGIN_W-1:0] end_margin_reg;
    logic [EPOCH_LEN_W-1:0]  epoch_len_reg;

    // persistent state
    logic [POS_WIDTH-1:0]  position_reg, position_next;
    logic [POS_WIDTH-1:0]  ref_pos_reg;
    logic signed [Q_W-1:0] w_off_reg, w_off_next;
    logic signed [Q_W-1:0] w_slp_reg, w_slp_next;

    // per-transaction registers
    logic                    gated_reg;
    logic                    last_reg;
    logic signed [U1_W-1:0]  u1_reg;
    logic signed [SMP_W-1:0] smp_reg;
    logic signed [MUL_W-1:0] prod_reg;
    logic signed [Q_W-1:0]   err_reg, err_next;
    logic [DEN_W-1:0]        den_reg;
    logic                    neg_reg [2];
    logic [REM_W-1:0]        rem_reg [2];
    logic [DVD_W-1:0]        dvd_reg [2];

    // output register
    logic [Q_W-1:0] out_off_reg, out_slp_reg, out_err_reg;
    logic           out_adapted_reg, out_done_reg;

    // gate and position logic
    logic [CMP_W-1:0]       pos_x, on_x, em_x, edge_x, el_x;
    logic                   gate_now, near_start, last_now;
    logic [POS_WIDTH-1:0]   ref_now;
    logic signed [U1_W-1:0] u1_now;

    assign pos_x  = CMP_W'(position_reg);
    assign on_x   = CMP_W'(on_start_reg);
    assign em_x   = CMP_W'(end_margin_reg);
    assign edge_x = CMP_W'(edge_pos);
    assign el_x   = CMP_W'(epoch_len_reg);

    assign gate_now   = (pos_x > on_x) && ((pos_x + em_x) < edge_x);
    assign near_start = pos_x <= (on_x + CMP_W'(2));
    assign last_now   = ((pos_x + CMP_W'(1)) >= el_x) || (&position_reg);
    assign ref_now    = (gate_now && near_start) ? position_reg : ref_pos_reg;
    assign u1_now     = U1_W'({1'b0, position_reg}) - U1_W'({1'b0, ref_now});

    assign position_next = last_now ? '0 : position_reg + POS_WIDTH'(1);
    assign status.gated  = gate_now;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_start_reg   <= ON_START_RST;
            end_margin_reg <= END_MARGIN_RST;
            epoch_len_reg  <= EPOCH_LEN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ON_START:     on_start_reg   <= cfg_data[ON_START_W-1:0];
                CFG_END_MARGIN:   end_margin_reg <= cfg_data[END_MARGIN_W-1:0];
                CFG_EPOCH_LENGTH: epoch_len_reg  <= cfg_data[EPOCH_LEN_W-1:0];
                default:          on_start_reg   <= on_start_reg;
            endcase
        end
    end

    // shared 32 x u1 multiplier
    logic signed [Q_W-1:0]   mul_a;
    logic signed [MUL_W-1:0] mul_p;

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_PRED: mul_a = w_slp_reg;
            MUL_SQR:  mul_a = {{(Q_W - U1_W){u1_reg[U1_W-1]}}, u1_reg};
            MUL_NUM:  mul_a = err_reg;
            default:  mul_a = w_slp_reg;
        endcase
    end

    assign mul_p = mul_a * u1_reg;

    // prediction error, saturated to q16.16
    logic signed [DIFF_W-1:0] smp_x, woff_x, prod_x, diff;
    logic [DIFF_W-Q_W:0]      diff_hi;

    assign smp_x   = smp_reg;
    assign woff_x  = w_off_reg;
    assign prod_x  = prod_reg;
    assign diff    = smp_x - (woff_x + prod_x);
    assign diff_hi = diff[DIFF_W-1:Q_W-1];

    always_comb
    begin
        if ((&diff_hi) || !(|diff_hi))
        begin
            err_next = diff[Q_W-1:0];
        end
        else
        begin
            err_next = diff[DIFF_W-1] ? Q_MIN : Q_MAX;
        end
    end

    // divider operand magnitudes
    logic [Q_W-1:0]   err_mag;
    logic [MUL_W-1:0] prod_abs;

    assign err_mag  = err_reg[Q_W-1] ? (Q_W'(0) - err_reg) : err_reg;
    assign prod_abs = prod_reg[MUL_W-1] ? (MUL_W'(0) - prod_reg) : prod_reg;

    // two restoring division steps per cycle on both lanes
    logic [REM_W-1:0] rem_step [2];
    logic [DVD_W-1:0] dvd_step [2];

    always_comb
    begin : div_lanes
        logic [REM_W-1:0] r;
        logic [DVD_W-1:0] d;
        logic [REM_W-1:0] t;
        for (int l = 0; l < 2; l++)
        begin
            r = rem_reg[l];
            d = dvd_reg[l];
            for (int s = 0; s < 2; s++)
            begin
                t = {r[REM_W-2:0], d[DVD_W-1]};
                d = {d[DVD_W-2:0], 1'b0};
                if (t >= {1'b0, den_reg})
                begin
                    t    = t - {1'b0, den_reg};
                    d[0] = 1'b1;
                end
                r = t;
            end
            rem_step[l] = r;
            dvd_step[l] = d;
        end
    end

    // weight update with saturation
    logic [SUM_W-1:0]        q_ext [2];
    logic [SUM_W-1:0]        q_sgn [2];
    logic signed [SUM_W-1:0] woff_s, wslp_s;
    logic [SUM_W-1:0]        sum_off, sum_slp;
    logic [SUM_W-Q_W:0]      off_hi, slp_hi;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            q_ext[l] = SUM_W'(dvd_reg[l][NUM_W-1:0]);
            q_sgn[l] = neg_reg[l] ? (SUM_W'(0) - q_ext[l]) : q_ext[l];
        end
    end

    assign woff_s  = w_off_reg;
    assign wslp_s  = w_slp_reg;
    assign sum_off = woff_s + q_sgn[0];
    assign sum_slp = wslp_s + q_sgn[1];
    assign off_hi  = sum_off[SUM_W-1:Q_W-1];
    assign slp_hi  = sum_slp[SUM_W-1:Q_W-1];

    always_comb
    begin
        if ((&off_hi) || !(|off_hi))
        begin
            w_off_next = sum_off[Q_W-1:0];
        end
        else
        begin
            w_off_next = sum_off[SUM_W-1] ? Q_MIN : Q_MAX;
        end
        if ((&slp_hi) || !(|slp_hi))
        begin
            w_slp_next = sum_slp[Q_W-1:0];
        end
        else
        begin
            w_slp_next = sum_slp[SUM_W-1] ? Q_MIN : Q_MAX;
        end
    end

    // state that survives across transactions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            ref_pos_reg  <= '0;
            w_off_reg    <= '0;
            w_slp_reg    <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                position_reg <= position_next;
                ref_pos_reg  <= ref_now;
            end
            if (cmd.upd_en)
            begin
                w_off_reg <= w_off_next;
                w_slp_reg <= w_slp_next;
            end
        end
    end

    // per-transaction working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            gated_reg <= gate_now;
            last_reg  <= last_now;
            u1_reg    <= u1_now;
            smp_reg   <= {sample, SMP_SHIFT'(0)};
        end
        if (cmd.mul_en)
        begin
            prod_reg <= mul_p;
        end
        if (cmd.err_en)
        begin
            err_reg <= err_next;
        end
        if (cmd.den_en)
        begin
            den_reg <= prod_reg[DEN_W-1:0] + DEN_W'(1);
        end
        if (cmd.div_init)
        begin
            neg_reg[0] <= err_reg[Q_W-1];
            neg_reg[1] <= prod_reg[MUL_W-1];
            rem_reg[0] <= '0;
            rem_reg[1] <= '0;
            dvd_reg[0] <= DVD_W'(err_mag);
            dvd_reg[1] <= DVD_W'(prod_abs[NUM_W-1:0]);
        end
        else if (cmd.div_step)
        begin
            rem_reg[0] <= rem_step[0];
            rem_reg[1] <= rem_step[1];
            dvd_reg[0] <= dvd_step[0];
            dvd_reg[1] <= dvd_step[1];
        end
        if (cmd.out_load)
        begin
            out_off_reg     <= w_off_reg;
            out_slp_reg     <= w_slp_reg;
            out_err_reg     <= gated_reg ? err_reg : '0;
            out_adapted_reg <= gated_reg;
            out_done_reg    <= last_reg;
        end
    end

    assign weight_offset = out_off_reg;
    assign weight_slope  = out_slp_reg;
    assign pred_error    = out_err_reg;
    assign adapted       = out_adapted_reg;
    assign epoch_done    = out_done_reg;

endmodule

FILE: hw/rtl/gated_nlms_ramp_identifier.sv
// gated_nlms_ramp_identifier: top level of the gated two-weight nlms ramp fit
// joins the sequencer gnlms_ctrl and the datapath gnlms_dp
// depends on gnlms_pkg
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   input   | in_valid, in_ready, sample, edge_pos           | in
//   output  | out_valid, out_ready, weight_offset,           | out
//           | weight_slope, pred_error, adapted, epoch_done  |
//   config  | cfg_we, cfg_index, cfg_data                    | in
//
// a sample outside the gate goes from acceptance straight to the output load
// a gated sample passes through prediction, error, denominator, numerator, divide and
// update steps; the radix-4 divider runs both weight increments side by side
// one transaction is in work at a time; in_ready returns once the result is registered
// a stalled output holds only the final load, the next sample is accepted meanwhile
// reset is asynchronous, active low: weights, position and reference go to zero

module gated_nlms_ramp_identifier import gnlms_pkg::*; #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int POS_WIDTH    = 10
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [SAMPLE_WIDTH-1:0] sample,
    input  logic [POS_WIDTH-1:0]    edge_pos,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [Q_W-1:0]          weight_offset,
    output logic [Q_W-1:0]          weight_slope,
    output logic [Q_W-1:0]          pred_error,
    output logic                    adapted,
    output logic                    epoch_done
);

    localparam int DIV_ITERS = (Q_W + POS_WIDTH) / 2;

    cmd_t    cmd;
    status_t status;

    // sequencer
    gnlms_ctrl #(
        .DIV_ITERS (DIV_ITERS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath
    gnlms_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .POS_WIDTH    (POS_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .sample        (sample),
        .edge_pos      (edge_pos),
        .cmd           (cmd),
        .status        (status),
        .weight_offset (weight_offset),
        .weight_slope  (weight_slope),
        .pred_error    (pred_error),
        .adapted       (adapted),
        .epoch_done    (epoch_done)
    );

endmodule

FILE: hw/rtl/gnlms_checker.sv
// gnlms_checker: port-level assertions for gated_nlms_ramp_identifier
// bound to the top level below; depends on gnlms_pkg

module gnlms_checker import gnlms_pkg::*; (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input logic           out_valid,
    input logic           out_ready,
    input logic [Q_W-1:0] weight_offset,
    input logic [Q_W-1:0] pred_error,
    input logic           adapted
);

    // one transaction in work at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a transaction is in work");

    // an idle block stays ready until a transaction arrives
    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && !in_valid |=> in_ready)
        else $error("ready dropped without a transaction");

    // a sample outside the gate reports zero error
    a_no_adapt_zero_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !adapted |-> pred_error == '0)
        else $error("nonzero error on a sample that did not adapt");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(weight_offset) && $stable(pred_error))
        else $error("stalled result changed");

endmodule

bind gated_nlms_ramp_identifier gnlms_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .weight_offset (weight_offset),
    .pred_error    (pred_error),
    .adapted       (adapted)
);

FILE: tb/tb_gated_nlms_ramp_identifier.sv
// tb_gated_nlms_ramp_identifier: self-checking bench for the gated nlms ramp identifier
// directed table then random epochs of ramps and noise, checked against a local fit model
// depends on gnlms_pkg and gated_nlms_ramp_identifier
`timescale 1ns / 1ps

module tb_gated_nlms_ramp_identifier import gnlms_pkg::*;;

    localparam int SMP_W = 16;
    localparam int POS_W = 10;
    localparam int RANDOM_ITEMS = 1800;
    localparam int IDLE_PAUSE = 40;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam longint Q_HI = 64'sd2147483647;
    localparam longint Q_LO = -Q_HI - 1;

    typedef struct packed {
        logic [Q_W-1:0] w_off;
        logic [Q_W-1:0] w_slope;
        logic [Q_W-1:0] err;
        logic           adapted;
        logic           last;
    } fit_result_t;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_WRITE
    } row_kind_t;

    typedef struct {
        row_kind_t         kind;
        cfg_index_t        idx;
        logic [10:0]       value;
        logic [SMP_W-1:0]  smp;
        logic [POS_W-1:0]  edge_v;
        logic              typed;
        fit_result_t       res;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [SMP_W-1:0]      sample;
    logic [POS_W-1:0]      edge_pos;
    logic                  out_valid;
    logic                  out_ready;
    logic [Q_W-1:0]        weight_offset;
    logic [Q_W-1:0]        weight_slope;
    logic [Q_W-1:0]        pred_error;
    logic                  adapted;
    logic                  epoch_done;

    // expected value riding along with a directed transaction
    logic                  typed_on;
    fit_result_t           typed_res;

    // local copy of the fit state and registers
    logic [POS_W-1:0]      pos_q;
    logic [POS_W-1:0]      ref_q;
    logic signed [31:0]    woff_q;
    logic signed [31:0]    wslope_q;
    logic [9:0]            on_start_q;
    logic [9:0]            margin_q;
    logic [10:0]           elen_q;

    fit_result_t           pending_fits[$];
    stim_row_t             dir_rows[$];
    int                    mismatches;
    int                    results_seen;
    int                    items_sent;
    int                    rand_sent;
    int                    quiet_cycles;

    gated_nlms_ramp_identifier #(
        .SAMPLE_WIDTH(SMP_W),
        .POS_WIDTH   (POS_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .edge_pos     (edge_pos),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .weight_offset(weight_offset),
        .weight_slope (weight_slope),
        .pred_error   (pred_error),
        .adapted      (adapted),
        .epoch_done   (epoch_done)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // saturate to the signed q16.16 range
    function automatic longint clamp_q(input longint v);
        if (v > Q_HI)
            return Q_HI;
        if (v < Q_LO)
            return Q_LO;
        return v;
    endfunction

    // one gated nlms step on the local state
    function automatic fit_result_t fit_step(input logic [SMP_W-1:0] smp_in,
                                             input logic [POS_W-1:0] edge_in);
        longint      smp;
        longint      u1;
        longint      y;
        longint      e;
        longint      den;
        logic        gated;
        logic        last;
        fit_result_t r;
        smp = longint'($signed(smp_in)) * 256;
        e = 0;
        gated = (pos_q > on_start_q) && (int'(pos_q) + int'(margin_q) < int'(edge_in));
        if (gated)
        begin
            if (int'(pos_q) <= int'(on_start_q) + 2)
                ref_q = pos_q;
            u1 = longint'(pos_q) - longint'(ref_q);
            y = longint'(woff_q) + longint'(wslope_q) * u1;
            e = clamp_q(smp - y);
            den = 1 + u1 * u1;
            woff_q = 32'(clamp_q(longint'(woff_q) + e / den));
            wslope_q = 32'(clamp_q(longint'(wslope_q) + (e * u1) / den));
        end
        last = (int'(pos_q) + 1 >= int'(elen_q)) || (pos_q == {POS_W{1'b1}});
        pos_q = last ? '0 : pos_q + 1'b1;
        r.w_off = woff_q;
        r.w_slope = wslope_q;
        r.err = 32'(e);
        r.adapted = gated;
        r.last = last;
        return r;
    endfunction

    // table row builders
    function automatic stim_row_t sample_row(input logic [SMP_W-1:0] s,
                                             input logic [POS_W-1:0] e);
        stim_row_t row;
        row.kind = ROW_SAMPLE;
        row.idx = CFG_ON_START;
        row.value = '0;
        row.smp = s;
        row.edge_v = e;
        row.typed = 1'b0;
        row.res = '0;
        return row;
    endfunction

    function automatic stim_row_t checked_row(input logic [SMP_W-1:0] s,
                                              input logic [POS_W-1:0] e,
                                              input fit_result_t r);
        stim_row_t row;
        row = sample_row(s, e);
        row.typed = 1'b1;
        row.res = r;
        return row;
    endfunction

    function automatic stim_row_t write_row(input cfg_index_t idx, input logic [10:0] v);
        stim_row_t row;
        row = sample_row('0, '0);
        row.kind = ROW_WRITE;
        row.idx = idx;
        row.value = v;
        return row;
    endfunction

    // monitor: register writes, input transactions into the model, result checks, watchdog
    always @(posedge clk)
    begin
        fit_result_t got;
        fit_result_t want;
        fit_result_t pred;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ON_START:     on_start_q = cfg_data[9:0];
                    CFG_END_MARGIN:   margin_q = cfg_data[9:0];
                    CFG_EPOCH_LENGTH: elen_q = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                pred = fit_step(sample, edge_pos);
                pending_fits.push_back(typed_on ? typed_res : pred);
            end
            if (out_valid && out_ready)
            begin
                results_seen++;
                got = '{weight_offset, weight_slope, pred_error, adapted, epoch_done};
                if (pending_fits.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction: off=%h slope=%h err=%h",
                                 got.w_off, got.w_slope, got.err);
                end
                else
                begin
                    want = pending_fits.pop_front();
                    if (got.w_off !== want.w_off || got.w_slope !== want.w_slope ||
                        got.err !== want.err || got.adapted !== want.adapted ||
                        got.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("result %0d mismatch: exp off=%h slope=%h err=%h ad=%b done=%b",
                                     results_seen, want.w_off, want.w_slope, want.err,
                                     want.adapted, want.last);
                            $display("    got off=%h slope=%h err=%h ad=%b done=%b",
                                     got.w_off, got.w_slope, got.err, got.adapted,
                                     got.last);
                        end
                    end
                end
            end
            // watchdog on cycles with no transaction on either channel
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // receiver: random stalls, quiet stretches, and long holds to back up the input
    initial
    begin
        int stall_left;
        int next_hold;
        int r;
        stall_left = 0;
        next_hold = 300;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
                stall_left--;
            else if (results_seen >= next_hold)
            begin
                stall_left = HOLD_CYCLES;
                next_hold += 700;
            end
            else if ((results_seen / 150) % 4 != 3)
            begin
                r = $urandom_range(0, 99);
                if (r < 10)
                    stall_left = $urandom_range(1, 4);
                else if (r < 12)
                    stall_left = $urandom_range(15, 60);
            end
            out_ready <= (stall_left == 0);
        end
    end

    // sender gap length, none during quiet stretches
    function automatic int pick_gap();
        int r;
        if ((items_sent / 128) % 3 == 2)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 94)
            return $urandom_range(1, 4);
        return $urandom_range(15, 60);
    endfunction

    // offer one input transaction, starting and ending at a falling edge
    task automatic drive_sample(input logic [SMP_W-1:0] s, input logic [POS_W-1:0] e,
                                input logic typed, input fit_result_t r);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        sample <= s;
        edge_pos <= e;
        typed_on <= typed;
        typed_res <= r;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        items_sent++;
        @(negedge clk);
    endtask

    // let every result come back and the block settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_fits.size() != 0)
            @(negedge clk);
        repeat (IDLE_PAUSE) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [10:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // pick a gate register value, mostly small so the gate opens
    function automatic logic [9:0] pick_gate_reg();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 10'd0;
        if (r < 15)
            return 10'd1023;
        if (r < 25)
            return 10'($urandom_range(0, 1023));
        return 10'($urandom_range(0, 20));
    endfunction

    function automatic logic [10:0] pick_epoch_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 11'd0;
        if (r < 10)
            return 11'd1;
        if (r < 15)
            return 11'd2;
        if (r < 20)
            return 11'd1024;
        if (r < 25)
            return 11'd2047;
        if (r < 30)
            return 11'($urandom_range(2, 2047));
        return 11'($urandom_range(8, 80));
    endfunction

    // random epochs: mostly ramps under a fixed edge, some noise with a moving edge
    task automatic run_epochs(input int n_items);
        int p;
        int left;
        int seg;
        int k;
        int lo;
        int base;
        int slope;
        int v;
        int el;
        logic noisy;
        logic [POS_W-1:0] e;
        p = pos_q;
        el = elen_q;
        left = n_items;
        while (left > 0)
        begin
            if (el <= 1 || p + 1 >= el)
                seg = 1;
            else
                seg = (el > 1024 ? 1024 : el) - p;
            noisy = ($urandom_range(0, 99) < 15);
            lo = int'(on_start_q) + int'(margin_q) + 2;
            if ($urandom_range(0, 99) < 75 && lo <= 1023)
                e = POS_W'($urandom_range(lo, 1023));
            else
                e = POS_W'($urandom());
            base = $urandom_range(0, 40000) - 20000;
            slope = $urandom_range(0, 400) - 200;
            for (k = 0; k < seg && left > 0; k++)
            begin
                if (noisy)
                    drive_sample(SMP_W'($urandom()), POS_W'($urandom()), 1'b0, '0);
                else
                begin
                    v = base + slope * k + $urandom_range(0, 128) - 64;
                    if (v > 32767)
                        v = 32767;
                    if (v < -32768)
                        v = -32768;
                    drive_sample(SMP_W'(v), e, 1'b0, '0);
                end
                left--;
                rand_sent++;
            end
            p = (k == seg) ? 0 : p + k;
        end
    endtask

    task automatic set_config(input logic [9:0] on, input logic [9:0] m,
                              input logic [10:0] el);
        wait_idle();
        write_reg(CFG_ON_START, on);
        write_reg(CFG_END_MARGIN, m);
        write_reg(CFG_EPOCH_LENGTH, el);
    endtask

    // stimulus
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_ON_START;
        cfg_data = '0;
        in_valid = 1'b0;
        sample = '0;
        edge_pos = '0;
        out_ready = 1'b0;
        typed_on = 1'b0;
        typed_res = '0;
        pos_q = '0;
        ref_q = '0;
        woff_q = '0;
        wslope_q = '0;
        on_start_q = ON_START_RST;
        margin_q = END_MARGIN_RST;
        elen_q = EPOCH_LEN_RST;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        rand_sent = 0;
        quiet_cycles = 0;

        // directed: reset registers, closed gate at the epoch start, extreme samples
        dir_rows.push_back(checked_row(16'h7FFF, 10'd1023, '0));
        dir_rows.push_back(checked_row(16'h8000, 10'd0, '0));
        dir_rows.push_back(checked_row(16'h0001, 10'd512, '0));
        dir_rows.push_back(checked_row(16'hFFFF, 10'd1023, '0));
        dir_rows.push_back(checked_row(16'h1234, 10'd1023, '0));
        dir_rows.push_back(checked_row(16'h5555, 10'd1023, '0));
        // first gated sample sets the reference, so u1 is zero and the step is the full error
        dir_rows.push_back(checked_row(16'h7FFF, 10'd1023,
                           '{32'h007F_FF00, 32'h0, 32'h007F_FF00, 1'b1, 1'b0}));
        dir_rows.push_back(checked_row(16'h8000, 10'd1023,
                           '{32'hFF80_0000, 32'h0, 32'hFF00_0100, 1'b1, 1'b0}));
        dir_rows.push_back(sample_row(16'h0000, 10'd1023));
        dir_rows.push_back(sample_row(16'h2AAA, 10'd12));
        dir_rows.push_back(sample_row(16'h7FFF, 10'd1023));
        // epoch length below the position ends the epoch at once, zero and one end every sample
        dir_rows.push_back(write_row(CFG_EPOCH_LENGTH, 11'd0));
        dir_rows.push_back(sample_row(16'h4000, 10'd1023));
        dir_rows.push_back(sample_row(16'hC000, 10'd1023));
        dir_rows.push_back(write_row(CFG_EPOCH_LENGTH, 11'd1));
        dir_rows.push_back(sample_row(16'h00FF, 10'd1023));
        // widest gate and longest epoch
        dir_rows.push_back(write_row(CFG_ON_START, 11'd0));
        dir_rows.push_back(write_row(CFG_END_MARGIN, 11'd0));
        dir_rows.push_back(write_row(CFG_EPOCH_LENGTH, 11'd2047));
        dir_rows.push_back(sample_row(16'h7FFF, 10'd1023));
        dir_rows.push_back(sample_row(16'h8000, 10'd1023));
        dir_rows.push_back(sample_row(16'h0000, 10'd2));
        // gate that can never open
        dir_rows.push_back(write_row(CFG_ON_START, 11'd1023));
        dir_rows.push_back(write_row(CFG_END_MARGIN, 11'd1023));
        dir_rows.push_back(sample_row(16'h7FFF, 10'd1023));
        dir_rows.push_back(sample_row(16'h8000, 10'd1023));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_WRITE)
            begin
                wait_idle();
                write_reg(dir_rows[i].idx, dir_rows[i].value);
            end
            else
                drive_sample(dir_rows[i].smp, dir_rows[i].edge_v, dir_rows[i].typed,
                             dir_rows[i].res);
        end

        // one long epoch that runs the position counter to its top and wraps
        set_config(10'($urandom_range(0, 8)), 10'($urandom_range(0, 8)), 11'd2047);
        run_epochs(1024 - int'(pos_q) + 12);

        // random settings, each phase a run of epochs
        while (rand_sent < RANDOM_ITEMS)
        begin
            set_config(pick_gate_reg(), pick_gate_reg(), pick_epoch_len());
            run_epochs($urandom_range(40, 150));
        end

        wait_idle();
        if (pending_fits.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/gnlms_pkg.sv
hw/rtl/gnlms_ctrl.sv
hw/rtl/gnlms_dp.sv
hw/rtl/gated_nlms_ramp_identifier.sv
hw/rtl/gnlms_checker.sv
tb/tb_gated_nlms_ramp_identifier.sv
